// ===== rtl/dltq_pkg.sv =====
// Shared constants for the delta-list timer queue.
// Depends on nothing; used by the top level and the checker.
package dltq_pkg;
  localparam int SLOT_COUNT = 16;
  localparam int ID_W       = 4;
  localparam int CNT_W      = 5;
  localparam int TICK_W     = 32;
  localparam int REP_W      = 16;
  localparam logic [CNT_W-1:0] LIST_CAP = CNT_W'(SLOT_COUNT);

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic ST_OK     = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [CNT_W-1:0]  cnt_t;
endpackage

// ===== rtl/delta_list_timer_queue_unit.sv =====
// Delta-list timer queue: sorted timer list with one shared compare/subtract unit.
// Depends on dltq_pkg.
// Sequence: an accepted start walks the list to its place and then gives a single
// result, a rejected start gives its single result without a walk; a tick scans the due
// head entries, fires each, reinserting a repeating timer by a walk, closes the fire
// phase, ages the first pending entry, then gives one result per fired timer (one if none fired). Busy
// stays high until the last result is issued; the receiver cannot stall, so results
// leave one per cycle. Synchronous active-low reset empties the list and clears all slots.
module delta_list_timer_queue_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic [dltq_pkg::ID_W-1:0]   in_timer_id,
  input  logic [dltq_pkg::TICK_W-1:0] in_delay_ticks,
  input  logic [dltq_pkg::REP_W-1:0]  in_repeat_count,
  output logic                     out_valid,
  output logic                     out_fired,
  output logic [dltq_pkg::ID_W-1:0]   out_fired_id,
  output logic                     out_status,
  output logic [dltq_pkg::CNT_W-1:0]  out_active_count,
  output logic                     out_last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIRE = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_r;

  // list in order, deltas relative to the entry in front
  dltq_pkg::id_t   ids_r    [dltq_pkg::SLOT_COUNT];
  dltq_pkg::tick_t delta_r  [dltq_pkg::SLOT_COUNT];
  // per-slot reload and remaining repeat
  dltq_pkg::tick_t reload_r [dltq_pkg::SLOT_COUNT];
  logic [dltq_pkg::REP_W-1:0] repeat_r [dltq_pkg::SLOT_COUNT];
  logic [dltq_pkg::SLOT_COUNT-1:0] active_r;
  // ids fired during the current tick, replayed in the result phase
  dltq_pkg::id_t   fbuf_r   [dltq_pkg::SLOT_COUNT];

  dltq_pkg::cnt_t  len_r;
  dltq_pkg::cnt_t  pos_r;
  dltq_pkg::tick_t rem_r;
  dltq_pkg::id_t   ins_id_r;
  logic            tick_r;
  logic            status_r;
  dltq_pkg::cnt_t  due_r;
  dltq_pkg::cnt_t  nfire_r;
  dltq_pkg::cnt_t  rd_r;

  logic            out_valid_r, out_fired_r, out_status_r, out_last_r;
  dltq_pkg::id_t   out_id_r;
  dltq_pkg::cnt_t  out_cnt_r;

  // shared unit: one compare/subtract against the delta at the walk position
  logic            at_entry;
  dltq_pkg::tick_t cur_delta;
  dltq_pkg::id_t   head_id;
  logic            emit_fired, emit_last;

  assign at_entry   = (pos_r < len_r);
  assign cur_delta  = delta_r[pos_r[dltq_pkg::ID_W-1:0]];
  assign head_id    = ids_r[0];
  assign emit_fired = tick_r && (nfire_r != '0);
  assign emit_last  = emit_fired ? (rd_r == nfire_r - 1'b1) : 1'b1;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_EMIT);
      case (state_r)
        S_IDLE: begin
          if (start) begin
            rd_r    <= '0;
            nfire_r <= '0;
            pos_r   <= '0;
            if (in_command == dltq_pkg::CMD_START) begin
              tick_r <= 1'b0;
              if (active_r[in_timer_id] || len_r >= dltq_pkg::LIST_CAP) begin
                status_r <= dltq_pkg::ST_REJECT;
                state_r  <= S_EMIT;
              end else begin
                status_r              <= dltq_pkg::ST_OK;
                reload_r[in_timer_id] <= in_delay_ticks;
                repeat_r[in_timer_id] <= in_repeat_count;
                active_r[in_timer_id] <= 1'b1;
                rem_r                 <= in_delay_ticks;
                ins_id_r              <= in_timer_id;
                state_r               <= S_WALK;
              end
            end else begin
              tick_r   <= 1'b1;
              status_r <= dltq_pkg::ST_OK;
              state_r  <= S_SCAN;
            end
          end
        end
        S_WALK: begin
          if (at_entry && rem_r >= cur_delta) begin
            // step past an entry that expires no later
            rem_r <= rem_r - cur_delta;
            pos_r <= pos_r + 1'b1;
          end else begin
            // open a gap, place the entry, rebase its successor
            for (int k = 1; k < dltq_pkg::SLOT_COUNT; k++) begin
              if (dltq_pkg::cnt_t'(k) > pos_r && dltq_pkg::cnt_t'(k) <= len_r) begin
                ids_r[k]   <= ids_r[k-1];
                delta_r[k] <= (dltq_pkg::cnt_t'(k) == pos_r + 1'b1) ?
                              cur_delta - rem_r : delta_r[k-1];
              end
            end
            ids_r[pos_r[dltq_pkg::ID_W-1:0]]   <= ins_id_r;
            delta_r[pos_r[dltq_pkg::ID_W-1:0]] <= rem_r;
            len_r   <= len_r + 1'b1;
            state_r <= tick_r ? S_FIRE : S_EMIT;
          end
        end
        S_SCAN: begin
          // count the head entries already due
          if (at_entry && cur_delta == '0) begin
            pos_r <= pos_r + 1'b1;
          end else begin
            due_r   <= pos_r;
            state_r <= S_FIRE;
          end
        end
        S_FIRE: begin
          if (nfire_r == due_r) begin
            pos_r   <= '0;
            state_r <= S_DEC;
          end else begin
            for (int k = 0; k < dltq_pkg::SLOT_COUNT - 1; k++) begin
              ids_r[k]   <= ids_r[k+1];
              delta_r[k] <= delta_r[k+1];
            end
            len_r                               <= len_r - 1'b1;
            fbuf_r[nfire_r[dltq_pkg::ID_W-1:0]] <= head_id;
            nfire_r                             <= nfire_r + 1'b1;
            if (repeat_r[head_id] == dltq_pkg::REP_W'(1)) begin
              active_r[head_id] <= 1'b0;
            end else begin
              if (repeat_r[head_id] > dltq_pkg::REP_W'(1))
                repeat_r[head_id] <= repeat_r[head_id] - 1'b1;
              rem_r    <= reload_r[head_id];
              ins_id_r <= head_id;
              pos_r    <= '0;
              state_r  <= S_WALK;
            end
          end
        end
        S_DEC: begin
          // age the first pending entry by one tick
          if (at_entry) begin
            if (cur_delta != '0) begin
              delta_r[pos_r[dltq_pkg::ID_W-1:0]] <= cur_delta - 1'b1;
              state_r <= S_EMIT;
            end else begin
              pos_r <= pos_r + 1'b1;
            end
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_fired_r  <= emit_fired;
          out_id_r     <= emit_fired ? fbuf_r[rd_r[dltq_pkg::ID_W-1:0]] : '0;
          out_status_r <= status_r;
          out_cnt_r    <= len_r;
          out_last_r   <= emit_last;
          rd_r         <= rd_r + 1'b1;
          if (emit_last)
            state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fired        = out_fired_r;
  assign out_fired_id     = out_id_r;
  assign out_status       = out_status_r;
  assign out_active_count = out_cnt_r;
  assign out_last         = out_last_r;

endmodule

// ===== rtl/dltq_checker.sv =====
// Port-level checks for the delta-list timer queue, bound to the top level.
// Depends on dltq_pkg and delta_list_timer_queue_unit.
module dltq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic                      out_fired,
  input logic [dltq_pkg::ID_W-1:0]  out_fired_id,
  input logic                      out_status,
  input logic [dltq_pkg::CNT_W-1:0] out_active_count,
  input logic                      out_last
);
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_active_count <= dltq_pkg::LIST_CAP) else $error("count over capacity");
  a_idle_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fired |-> out_fired_id == '0) else $error("id on non-fire item");
  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_fired && out_last) else $error("bad reject item");
  a_burst_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid) else $error("gap inside result burst");
endmodule

bind delta_list_timer_queue_unit dltq_checker u_dltq_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_fired(out_fired), .out_fired_id(out_fired_id), .out_status(out_status),
  .out_active_count(out_active_count), .out_last(out_last)
);
